[design/signal_pending_dispatch_assert.svh]
// Assertion macros for the signal engine.
`ifndef SIGNAL_PENDING_DISPATCH_ASSERT_SVH
`define SIGNAL_PENDING_DISPATCH_ASSERT_SVH

// Same-cycle implication.
`define SPD_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SPD_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/spd_pkg.sv]
package spd_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int NUM_SIG         = 32;
   localparam int PID_BITS        = 16;

   localparam logic [2:0] MODE_POST      = 3'd0;
   localparam logic [2:0] MODE_DISPATCH  = 3'd1;
   localparam logic [2:0] MODE_PURGE     = 3'd2;
   localparam logic [2:0] MODE_EXEC      = 3'd3;
   localparam logic [2:0] MODE_SET_ACT   = 3'd4;
   localparam logic [2:0] MODE_SET_MASK  = 3'd5;
   localparam logic [2:0] MODE_SET_ALARM = 3'd6;

   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_IGNORED = 3'd1;
   localparam logic [2:0] ACT_TERM    = 3'd2;
   localparam logic [2:0] ACT_STOP    = 3'd3;
   localparam logic [2:0] ACT_HANDLER = 3'd4;
   localparam logic [2:0] ACT_CONT    = 3'd5;
   localparam logic [2:0] ACT_DROPPED = 3'd6;

   localparam logic [4:0] SIG_NONE  = 5'd0;
   localparam logic [4:0] SIG_KILL  = 5'd9;
   localparam logic [4:0] SIG_USR1  = 5'd10;
   localparam logic [4:0] SIG_USR2  = 5'd12;
   localparam logic [4:0] SIG_ALRM  = 5'd14;
   localparam logic [4:0] SIG_CHLD  = 5'd17;
   localparam logic [4:0] SIG_CONT  = 5'd18;
   localparam logic [4:0] SIG_STOP  = 5'd19;
   localparam logic [4:0] SIG_TSTP  = 5'd20;
   localparam logic [4:0] SIG_TTIN  = 5'd21;
   localparam logic [4:0] SIG_TTOU  = 5'd22;
   localparam logic [4:0] SIG_URG   = 5'd23;
   localparam logic [4:0] SIG_WINCH = 5'd28;

   localparam logic [1:0] KIND_DFL = 2'd0;
   localparam logic [1:0] KIND_IGN = 2'd1;
   localparam logic [1:0] KIND_HND = 2'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [4:0]  signal;
      logic [15:0] child_id;
      logic [63:0] now;
      logic [1:0]  disposition;
      logic [31:0] block_mask;
      logic        no_defer;
      logic        reset_on_entry;
      logic [31:0] new_mask;
      logic [63:0] alarm_time;
   } spd_req_type;

   typedef struct packed {
      logic [4:0]  signal_taken;
      logic [2:0]  action;
      logic        queued;
      logic        task_continues;
      logic [31:0] blocked_mask;
      logic        overflow;
      logic [4:0]  pending_count;
   } spd_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } spd_state_type;

   typedef struct packed {
      logic capture;
      logic scan;
      logic finish;
   } spd_cmd_type;

   typedef struct packed {
      logic scan_done;
   } spd_stat_type;

   function automatic logic default_ignored(input logic [4:0] s);
      return s == SIG_CHLD || s == SIG_URG || s == SIG_WINCH ||
             s == SIG_USR1 || s == SIG_USR2 || s == SIG_CONT;
   endfunction

   function automatic logic [31:0] sig_bit(input logic [4:0] s);
      return (s == SIG_NONE) ? 32'd0 : (32'd1 << (s - 5'd1));
   endfunction

endpackage

[design/spd_ctrl.sv]
module spd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  spd_pkg::spd_stat_type stat,
   output spd_pkg::spd_cmd_type  cmd
);
   import spd_pkg::*;

   spd_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.scan_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      busy = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            cmd.capture = start;
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[design/spd_datapath.sv]
`include "signal_pending_dispatch_assert.svh"

module spd_datapath #(
   parameter int QUEUE_DEPTH = spd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  spd_pkg::spd_cmd_type  cmd,
   output spd_pkg::spd_stat_type stat,
   input  spd_pkg::spd_req_type  req_word,
   output logic                 rsp_valid,
   output spd_pkg::spd_rsp_type  rsp_word
);
   import spd_pkg::*;

   localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

   logic [4:0]          mem_sig   [QUEUE_DEPTH];
   logic [PID_BITS-1:0] mem_child [QUEUE_DEPTH];

   spd_req_type req_ff, req_in;
   logic [CW-1:0] used_ff, used_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          found_ff, found_in;
   logic [4:0]    taken_ff, taken_in;
   logic [4:0]          rd_sig_ff;
   logic [PID_BITS-1:0] rd_child_ff;
   logic [1:0]  kind_ff  [NUM_SIG];
   logic [1:0]  kind_in  [NUM_SIG];
   logic [31:0] block_ff [NUM_SIG];
   logic [31:0] block_in [NUM_SIG];
   logic [1:0]  flags_ff [NUM_SIG];
   logic [1:0]  flags_in [NUM_SIG];
   logic [31:0] mask_ff, mask_in;
   logic [63:0] alarm_ff, alarm_in;
   logic        rsp_valid_ff;
   spd_rsp_type rsp_ff, rsp_in;

   logic                we;
   logic [QW-1:0]       waddr;
   logic [4:0]          wsig;
   logic [PID_BITS-1:0] wchild;

   logic is_scan, rd_more, elig, match, drop;

   assign is_scan = req_ff.mode == MODE_DISPATCH || req_ff.mode == MODE_PURGE;
   assign rd_more = rd_idx_ff != used_ff;
   assign stat.scan_done = !is_scan || (!rd_more && !rd_vld_ff);
   assign elig = !found_ff && (rd_sig_ff == SIG_KILL || rd_sig_ff == SIG_STOP ||
                 (mask_ff & sig_bit(rd_sig_ff)) == 32'd0);
   assign match = rd_sig_ff == SIG_CHLD && rd_child_ff == req_ff.child_id[PID_BITS-1:0];
   assign drop = (req_ff.mode == MODE_DISPATCH) ? elig : match;

   always_comb begin
      logic [4:0]  s;
      logic [4:0]  hs;
      logic        do_h;
      logic        alarm_due;
      logic [1:0]  hk;
      logic [2:0]  act;
      logic        cont;

      req_in    = req_ff;
      used_in   = used_ff;
      rd_idx_in = rd_idx_ff;
      wr_idx_in = wr_idx_ff;
      rd_vld_in = rd_vld_ff;
      found_in  = found_ff;
      taken_in  = taken_ff;
      kind_in   = kind_ff;
      block_in  = block_ff;
      flags_in  = flags_ff;
      mask_in   = mask_ff;
      alarm_in  = alarm_ff;
      rsp_in    = rsp_ff;
      we        = 1'b0;
      waddr     = wr_idx_ff[QW-1:0];
      wsig      = rd_sig_ff;
      wchild    = rd_child_ff;
      s         = req_ff.signal;
      alarm_due = alarm_ff != 64'd0 && req_ff.now >= alarm_ff;
      hs        = found_ff ? taken_ff : SIG_ALRM;
      do_h      = found_ff || alarm_due;
      hk        = kind_ff[hs];
      act       = ACT_NONE;
      cont      = 1'b1;

      if (cmd.capture) begin
         req_in    = req_word;
         rd_idx_in = '0;
         wr_idx_in = '0;
         rd_vld_in = 1'b0;
         found_in  = 1'b0;
         taken_in  = SIG_NONE;
      end else if (cmd.scan && is_scan) begin
         rd_vld_in = rd_more;
         if (rd_more) rd_idx_in = rd_idx_ff + 1'b1;
         if (rd_vld_ff) begin
            if (drop) begin
               if (req_ff.mode == MODE_DISPATCH) begin
                  found_in = 1'b1;
                  taken_in = rd_sig_ff;
               end
            end else begin
               we        = 1'b1;
               wr_idx_in = wr_idx_ff + 1'b1;
            end
         end
      end else if (cmd.finish) begin
         rsp_in = '0;
         case (req_ff.mode)
            MODE_POST: begin
               if (s == SIG_CONT) act = ACT_CONT;
               if (s == SIG_NONE) begin
                  if (act == ACT_NONE) act = ACT_DROPPED;
               end else if (s != SIG_KILL && s != SIG_STOP && (kind_ff[s] == KIND_IGN ||
                            (kind_ff[s] == KIND_DFL && default_ignored(s)))) begin
                  if (act == ACT_NONE) act = ACT_IGNORED;
               end else if (used_ff == FULL) begin
                  rsp_in.overflow = 1'b1;
                  if (act == ACT_NONE) act = ACT_DROPPED;
               end else begin
                  we     = 1'b1;
                  waddr  = used_ff[QW-1:0];
                  wsig   = s;
                  wchild = req_ff.child_id[PID_BITS-1:0];
                  used_in = used_ff + 1'b1;
                  rsp_in.queued = 1'b1;
               end
            end
            MODE_DISPATCH: begin
               used_in = wr_idx_ff;
               if (!found_ff && alarm_due) alarm_in = 64'd0;
               if (do_h) begin
                  rsp_in.signal_taken = hs;
                  if (hs == SIG_KILL) begin
                     act = ACT_TERM;
                     cont = 1'b0;
                  end else if (hs == SIG_STOP) begin
                     act = ACT_STOP;
                     cont = 1'b0;
                  end else if (hk == KIND_DFL) begin
                     if (default_ignored(hs)) begin
                        act = ACT_IGNORED;
                     end else begin
                        cont = 1'b0;
                        act = (hs == SIG_TSTP || hs == SIG_TTIN || hs == SIG_TTOU) ?
                              ACT_STOP : ACT_TERM;
                     end
                  end else if (hk == KIND_IGN) begin
                     act = ACT_IGNORED;
                  end else begin
                     act = ACT_HANDLER;
                     mask_in = mask_ff | block_ff[hs] |
                               (flags_ff[hs][0] ? 32'd0 : sig_bit(hs));
                     if (flags_ff[hs][1]) kind_in[hs] = KIND_DFL;
                  end
               end
            end
            MODE_PURGE: begin
               used_in = wr_idx_ff;
            end
            MODE_EXEC: begin
               used_in = '0;
               for (int i = 0; i < NUM_SIG; i++) begin
                  flags_in[i] = 2'd0;
                  if (kind_ff[i] != KIND_IGN) kind_in[i] = KIND_DFL;
               end
            end
            MODE_SET_ACT: begin
               if (s != SIG_NONE && s != SIG_KILL && s != SIG_STOP &&
                   req_ff.disposition <= KIND_HND) begin
                  kind_in[s]  = req_ff.disposition;
                  block_in[s] = req_ff.block_mask;
                  flags_in[s] = {req_ff.reset_on_entry, req_ff.no_defer};
               end
            end
            MODE_SET_MASK: begin
               mask_in = req_ff.new_mask;
            end
            MODE_SET_ALARM: begin
               alarm_in = req_ff.alarm_time;
            end
            default: begin
               act = ACT_NONE;
            end
         endcase
         rsp_in.action         = act;
         rsp_in.task_continues = cont;
         rsp_in.blocked_mask   = mask_in;
         rsp_in.pending_count  = 5'(used_in);
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_sig[waddr]   <= wsig;
         mem_child[waddr] <= wchild;
      end
      rd_sig_ff   <= mem_sig[rd_idx_ff[QW-1:0]];
      rd_child_ff <= mem_child[rd_idx_ff[QW-1:0]];
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      taken_ff  <= taken_in;
      rsp_ff    <= rsp_in;
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      if (reset) begin
         used_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         mask_ff      <= '0;
         alarm_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SIG; i++) begin
            kind_ff[i]  <= KIND_DFL;
            block_ff[i] <= '0;
            flags_ff[i] <= '0;
         end
      end else begin
         used_ff      <= used_in;
         rd_vld_ff    <= rd_vld_in;
         found_ff     <= found_in;
         mask_ff      <= mask_in;
         alarm_ff     <= alarm_in;
         rsp_valid_ff <= cmd.finish;
         kind_ff      <= kind_in;
         block_ff     <= block_in;
         flags_ff     <= flags_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `SPD_ASSERT_NOW(a_used_bound, 1'b1, used_ff <= FULL, "queue count past depth")
   `SPD_ASSERT_NOW(a_wr_behind_rd, cmd.scan, wr_idx_ff <= rd_idx_ff, "write pointer ahead of read")
   `SPD_ASSERT_NEXT(a_rsp_after_finish, cmd.finish, rsp_valid_ff, "missing response strobe")

endmodule

[design/signal_pending_dispatch.sv]
// Sequence: start captures the request; the scan state sweeps the queue for dispatch
// and purge child but not post, exec reset or set modes; finish registers the result.
// Throughput: one word at a time; dispatch and purge sweep the pending queue
// through its memory, one entry per cycle, so busy holds that long.
// Reset: synchronous, active high; empties the queue, sets all dispositions to
// default, clears mask and alarm. The result cannot be stalled.
module signal_pending_dispatch #(
   parameter int QUEUE_DEPTH = spd_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  spd_pkg::spd_req_type req_word,
   output logic                rsp_valid,
   output spd_pkg::spd_rsp_type rsp_word
);
   import spd_pkg::*;

   spd_cmd_type  cmd;
   spd_stat_type stat;

   spd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   spd_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
